[src/ktp_pkg.sv]
// ktp_pkg: types, constants and helper functions for the keyed table prng
// no dependencies
package ktp_pkg;

    localparam logic [31:0] C_FMIX_1 = 32'h85ebca6b;
    localparam logic [31:0] C_FMIX_2 = 32'hc2b2ae35;
    localparam logic [31:0] C_GUARD_L = 32'h38916df4;
    localparam logic [31:0] C_GUARD_M = 32'h6c26fc92;
    localparam logic [31:0] C_STEP_L = 32'h9e3779b7;
    localparam logic [31:0] C_STEP_M = 32'h06a0dd9b;
    localparam logic [7:0] C_CYCLE_LEN = 8'hff;

    // table geometry, fixed at 256 entries
    localparam int C_TABLE_DEPTH = 256;
    localparam int C_AW = $clog2(C_TABLE_DEPTH);
    typedef logic [C_AW-1:0] t_idx;
    localparam t_idx C_LAST_IDX = t_idx'(C_TABLE_DEPTH - 1);

    localparam logic C_REQ_NEXT = 1'b0;
    localparam logic C_REQ_RESTART = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_KEY,
        S_FILL,
        S_RESEED,
        S_WIN,
        S_MIX,
        S_SWAP,
        S_OUT
    } t_state;

    // rotate left by the low five bits of r
    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] r);
        logic [63:0] w;
        w = {v, v} << r;
        return w[63:32];
    endfunction

endpackage

[src/ktp_if.sv]
// ktp_if: valid/ready channel carrying a generic payload
// depends on nothing
interface ktp_if #(
    parameter int WIDTH = 33
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[src/keyed_table_prng_with_reseed_core.sv]
// keyed_table_prng_with_reseed_core: top level sequencer with tables L and M
// depends on ktp_pkg, ktp_if, ktp_mul
//
// channel  dir  payload
// i_req    in   {req_type, seed_key}  (req_type at bit 32)
// o_rsp    out  {random_word, current_constant}  (random_word at 63:32)
//
// a plain word goes from one request to the next through the accept cycle,
// the window reads, the mix, the swap (single table port) and the output load
// a restart adds key hashing and a fill of every table entry before the window
// reads (one shared multiplier); a reseed adds a fold pass over every entry
// reset is synchronous and clears control state; the tables are undefined until a restart
// a result waits in the output register; the next request is still taken and only
// its output load stalls while that register is full
module keyed_table_prng_with_reseed_core
    import ktp_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    ktp_if.sink   i_req,
    ktp_if.source o_rsp
);
    t_state r_state, n_state;
    logic [31:0] r_l [C_TABLE_DEPTH];
    logic [31:0] r_m [C_TABLE_DEPTH];
    logic [31:0] r_lq, r_mq;
    t_idx l_addr, m_addr, l_waddr, m_waddr;
    logic l_we, m_we;
    logic [31:0] l_wdata, m_wdata;

    logic [31:0] r_const, r_chain, r_win, r_key, r_kl, r_km, r_sl, r_sm;
    logic [31:0] r_acc, r_x, r_word, r_li, r_out_word, r_out_const;
    logic [7:0]  r_lowb, r_pos;
    logic        r_started, r_ovalid;
    t_idx        r_idx;
    logic [3:0]  r_sub;

    logic [31:0] mul_a, mul_b, mul_p;
    logic [31:0] key_in_l, key_in_m, key_pre_l, key_pre_m, fm_mid, fm_post, fill_word;
    logic [31:0] fold_v, fold_x, fold_done;
    logic [31:0] mix_a, mix_b, mix_rot, mix_c;
    logic        accept, restart_req, out_load;
    t_idx        base_i;

    ktp_mul u_mul (.i_clk(i_clk), .i_a(mul_a), .i_b(mul_b), .o_p(mul_p));

    // handshakes
    assign accept = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data = {r_out_word, r_out_const};
    assign out_load = (r_state == S_OUT) && (!r_ovalid || o_rsp.ready);

    assign restart_req = (i_req.data[32] == C_REQ_RESTART) || !r_started;
    assign base_i = t_idx'(C_CYCLE_LEN - r_pos);

    // key hashing stages on the registered product
    assign key_in_l  = C_GUARD_L ^ mul_p;
    assign key_in_m  = C_GUARD_M ^ mul_p;
    assign key_pre_l = key_in_l ^ (key_in_l >> 16);
    assign key_pre_m = key_in_m ^ (key_in_m >> 16);
    assign fm_mid    = mul_p ^ (mul_p >> 13);
    assign fm_post   = mul_p ^ (mul_p >> 16);
    assign fill_word = rotl32(mul_p, r_key[4:0] ^ r_idx[4:0]);

    // reseed fold of one entry
    assign fold_v    = r_mq ^ r_lq;
    assign fold_x    = r_x ^ fold_v;
    assign fold_done = r_acc ^ (fold_x << r_idx[7:5]);

    // word mixing: a on the first mix cycle, c on the second
    assign mix_a   = ({24'd0, r_lowb} ^ r_win) ^ (r_const + r_chain);
    assign mix_b   = (r_const + r_x) ^ (r_win + {24'd0, r_lowb});
    assign mix_rot = rotl32((r_x >> 13) ^ r_x, mix_b[4:0]);
    assign mix_c   = mix_rot ^ (mix_rot >> 17);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (restart_req) n_state = S_KEY;
                    else if (r_pos >= C_CYCLE_LEN) n_state = S_RESEED;
                    else n_state = S_WIN;
                end
            end
            S_KEY:    if (r_sub == 4'd6) n_state = S_FILL;
            S_FILL:   if (r_sub == 4'd2 && r_idx == C_LAST_IDX) n_state = S_WIN;
            S_RESEED: if (r_sub == 4'd1 && r_idx == C_LAST_IDX) n_state = S_WIN;
            S_WIN:    if (r_sub == 4'd8) n_state = S_MIX;
            S_MIX:    if (r_sub == 4'd1) n_state = S_SWAP;
            S_SWAP:   if (r_sub == 4'd2) n_state = S_OUT;
            S_OUT:    if (out_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // multiplier operands and table port controls
    always_comb begin
        mul_a = r_key;
        mul_b = C_STEP_L;
        l_addr = r_idx;
        m_addr = r_idx;
        l_we = 1'b0;
        l_waddr = r_idx;
        l_wdata = fill_word;
        m_we = 1'b0;
        m_waddr = r_idx;
        m_wdata = fill_word;
        case (r_state)
            S_KEY: begin
                case (r_sub)
                    4'd1: begin mul_a = key_pre_l; mul_b = C_FMIX_1; end
                    4'd2: begin mul_a = fm_mid; mul_b = C_FMIX_2; end
                    4'd3: begin mul_a = r_key; mul_b = C_STEP_M; end
                    4'd4: begin mul_a = key_pre_m; mul_b = C_FMIX_1; end
                    4'd5: begin mul_a = fm_mid; mul_b = C_FMIX_2; end
                    default: ;
                endcase
            end
            S_FILL: begin
                case (r_sub)
                    4'd0: begin mul_a = r_sl; mul_b = r_kl; end
                    4'd1: begin
                        mul_a = r_sm;
                        mul_b = r_km;
                        l_we = 1'b1;
                    end
                    4'd2: m_we = 1'b1;
                    default: ;
                endcase
            end
            S_RESEED: begin
                if (r_sub == 4'd1) begin
                    m_we = 1'b1;
                    m_wdata = fold_v;
                end
            end
            S_WIN: begin
                l_addr = base_i;
                m_addr = base_i + t_idx'(r_sub);
            end
            S_SWAP: begin
                l_addr = r_lowb;
                case (r_sub)
                    4'd1: begin
                        l_we = 1'b1;
                        l_waddr = base_i;
                        l_wdata = r_lq;
                    end
                    4'd2: begin
                        l_we = 1'b1;
                        l_waddr = r_lowb;
                        l_wdata = r_li;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // step counter within a state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub <= '0;
        end else if (n_state != r_state) begin
            r_sub <= '0;
        end else if (r_state == S_FILL && r_sub == 4'd2) begin
            r_sub <= '0;
        end else if (r_state == S_RESEED && r_sub == 4'd1) begin
            r_sub <= '0;
        end else begin
            r_sub <= r_sub + 4'd1;
        end
    end

    // control and stream state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_started <= 1'b0;
            r_const <= '0;
            r_chain <= '0;
            r_lowb <= '0;
            r_win <= '0;
            r_pos <= '0;
            r_idx <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_idx <= '0;
                        if (restart_req) begin
                            r_const <= i_req.data[31:0];
                            r_chain <= i_req.data[31:0];
                            r_lowb <= '0;
                            r_pos <= '0;
                            r_started <= 1'b1;
                        end
                    end
                end
                S_FILL: if (r_sub == 4'd2) r_idx <= r_idx + t_idx'(1);
                S_RESEED: begin
                    if (r_sub == 4'd1) begin
                        r_idx <= r_idx + t_idx'(1);
                        if (r_idx == C_LAST_IDX) begin
                            r_const <= fold_done;
                            r_chain <= fold_done;
                            r_lowb <= '0;
                            r_pos <= '0;
                        end
                    end
                end
                S_WIN: begin
                    if (r_sub == 4'd0) r_win <= '0;
                    else r_win <= r_win ^ (r_mq << (r_sub - 4'd1));
                end
                S_MIX: begin
                    if (r_sub == 4'd1) begin
                        r_chain <= r_x;
                        r_lowb <= mix_c[7:0];
                    end
                end
                S_SWAP: if (r_sub == 4'd2) r_pos <= r_pos + 8'd1;
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_key <= i_req.data[31:0];
                    r_sl <= '0;
                    r_sm <= '0;
                    r_acc <= '0;
                    r_x <= '0;
                end
            end
            S_KEY: begin
                case (r_sub)
                    4'd3: r_kl <= fm_post;
                    4'd6: r_km <= fm_post;
                    default: ;
                endcase
            end
            S_FILL: begin
                if (r_sub == 4'd2) begin
                    r_sl <= r_sl + C_STEP_L;
                    r_sm <= r_sm + C_STEP_M;
                end
            end
            S_RESEED: begin
                if (r_sub == 4'd1) begin
                    if (r_idx[4:0] == 5'd31) begin
                        r_acc <= fold_done;
                        r_x <= '0;
                    end else begin
                        r_x <= fold_x;
                    end
                end
            end
            S_WIN: if (r_sub == 4'd1) r_li <= r_lq;
            S_MIX: begin
                if (r_sub == 4'd0) r_x <= mix_a;
                else if (r_sub == 4'd1) r_word <= mix_c;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovalid <= 1'b0;
        else if (out_load) r_ovalid <= 1'b1;
        else if (o_rsp.ready) r_ovalid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_word <= r_word;
            r_out_const <= r_const;
        end
    end

    // table L port
    always_ff @(posedge i_clk) begin
        r_lq <= r_l[l_addr];
        if (l_we) r_l[l_waddr] <= l_wdata;
    end

    // table M port
    always_ff @(posedge i_clk) begin
        r_mq <= r_m[m_addr];
        if (m_we) r_m[m_waddr] <= m_wdata;
    end

    // assertions
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> (r_state == S_IDLE)) else $error("ready outside idle");
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_req.ready) else $error("two requests in flight");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ready) |=> (o_rsp.valid && $stable(o_rsp.data)))
        else $error("result changed");
endmodule

[src/ktp_mul.sv]
// ktp_mul: registered 32x32 multiplier, low word kept
// depends on ktp_pkg
module ktp_mul
    import ktp_pkg::*;
(
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_p
);
    logic [31:0] r_p;

    // product register
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;
endmodule
